### src/indexed_list_store_defines.svh
// Assertion macros shared by the ordered list store RTL.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock outside reset.
`define ILS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ils: same-cycle check failed");

// Next-cycle implication, checked on every rising clock outside reset.
`define ILS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ils: next-cycle check failed");

`else

`define ILS_ASSERT_IMPL(lbl, ante, cons)
`define ILS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/ils_pkg.sv
// Types and codes shared by the ordered list store modules.
`default_nettype none

package ils_pkg;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_FIND   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_INDEX    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   // Match bits examined per scan cycle; a power of two.
   localparam int GROUP_BITS = 8;
   localparam int GROUP_SEL  = 3;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  position;
      logic [31:0] item_value;
   } ils_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [3:0]  found_position;
      logic [4:0]  length;
      logic        is_empty;
   } ils_rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE,
      CELL_COMPARE
   } ils_cell_op_type;

   typedef struct packed {
      ils_cell_op_type op;
      logic [3:0]      position;
   } ils_cell_ctrl_type;

   typedef struct packed {
      logic       done;
      logic       found;
      logic [3:0] position;
   } ils_scan_result_type;

endpackage

`default_nettype wire

### src/ils_cell.sv
// One list entry: holds a word, shifts with its neighbors, compares on demand.
`default_nettype none

module ils_cell
   import ils_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   parameter int INDEX     = 0
) (
   input  wire                          clock,
   input  wire ils_cell_ctrl_type       ctrl,
   input  wire [$clog2(DEPTH+1)-1:0]    count,
   input  wire [WORD_BITS-1:0]          word_value,
   input  wire [WORD_BITS-1:0]          left_word,
   input  wire [WORD_BITS-1:0]          right_word,
   output logic [WORD_BITS-1:0]         word_out,
   output logic                         match_out
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 4;
   localparam logic [IW-1:0] IDX = IW'(INDEX);

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 match_ff, match_in;
   logic [IW-1:0]        pos_w, cnt_w;

   assign pos_w = IW'(ctrl.position);
   assign cnt_w = IW'(count);

   always_comb begin
      word_in  = word_ff;
      match_in = match_ff;
      case (ctrl.op)
         CELL_APPEND: begin
            if (IDX == cnt_w) begin
               word_in = word_value;
            end
         end
         CELL_INSERT: begin
            if (IDX == pos_w) begin
               word_in = word_value;
            end else if (IDX > pos_w && IDX <= cnt_w) begin
               word_in = left_word;
            end
         end
         CELL_DELETE: begin
            if (IDX >= pos_w && IDX + IW'(1) < cnt_w) begin
               word_in = right_word;
            end
         end
         CELL_COMPARE: begin
            match_in = (word_ff == word_value) && (IDX < cnt_w);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word_out  = word_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

### src/ils_scan.sv
// First-match scanner: walks the match vector one group per cycle.
`default_nettype none

module ils_scan
   import ils_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [DEPTH-1:0]      match,
   output ils_scan_result_type  result
);

   localparam int G    = (DEPTH + GROUP_BITS - 1) / GROUP_BITS;
   localparam int GW   = (G > 1) ? $clog2(G) : 1;
   localparam int PADW = G * GROUP_BITS;

   logic [PADW-1:0]                  padded;
   logic [G-1:0][GROUP_BITS-1:0]     groups;
   logic [GROUP_BITS-1:0]            grp;
   logic [GROUP_SEL-1:0]             enc;
   logic [GW-1:0]                    grp_ff, grp_in;
   logic                             active_ff, active_in;
   logic                             last;

   assign padded = PADW'(match);
   assign groups = padded;
   assign grp    = groups[grp_ff];
   assign last   = (grp_ff == GW'(G - 1));

   // Lowest set bit wins.
   always_comb begin
      enc = '0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
         if (grp[i]) begin
            enc = GROUP_SEL'(i);
         end
      end
   end

   always_comb begin
      result.done     = active_ff && ((|grp) || last);
      result.found    = active_ff && (|grp);
      result.position = {grp_ff[0], enc};
      active_in       = active_ff;
      grp_in          = grp_ff;
      if (start) begin
         active_in = 1'b1;
         grp_in    = '0;
      end else if (active_ff) begin
         if (result.done) begin
            active_in = 1'b0;
         end else begin
            grp_in = grp_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      grp_ff <= grp_in;
   end

endmodule

`default_nettype wire

### src/indexed_list_store.sv
// Top level of the ordered list store: command FSM, cell chain and response register.
//
//   channel   ports                    direction  transfer
//   request   start, busy, req_item    in         start high while busy low
//   response  rsp_strobe, rsp_item     out        every cycle rsp_strobe is high
//
// Append, insert, delete, read, clear and unused codes pass through the execute
// state and back to idle; the response strobes in the cycle busy drops. Find
// goes from execute to the scan state and stays there until the scanner, which
// checks eight match bits per cycle, reports the first match or runs out.
// Reset clears the FSM, the length and the response strobe; entries stay
// undefined until written. The receiver cannot stall: each response shows
// for exactly one cycle.
`default_nettype none
`include "indexed_list_store_defines.svh"

module indexed_list_store
   import ils_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  wire ils_req_type req_item,
   output logic         rsp_strobe,
   output ils_rsp_type  rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int RN = (DEPTH < 16) ? DEPTH : 16;
   localparam int RW = $clog2(RN);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } ils_state_type;

   ils_state_type state_ff, state_in;
   ils_req_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ils_rsp_type   rsp_ff, rsp_in;

   ils_cell_ctrl_type              cell_ctrl;
   logic [DEPTH-1:0][WORD_BITS-1:0] words;
   logic [RN-1:0][WORD_BITS-1:0]    rd_words;
   logic [DEPTH-1:0]               match;
   logic [WORD_BITS-1:0]           value;
   logic [WORD_BITS+31:0]          val_ext;
   logic [WORD_BITS+31:0]          rd_ext;
   logic [CW+4:0]                  len_ext;
   logic [CW+3:0]                  pos_cmp, cnt_cmp;
   logic                           pos_bad, full, accept, scan_start;
   ils_scan_result_type            scan_res;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // Fit the request word to the stored width, and back to the read port.
   assign val_ext  = {{WORD_BITS{1'b0}}, req_ff.item_value};
   assign value    = val_ext[WORD_BITS-1:0];
   assign rd_words = words[RN-1:0];
   assign rd_ext   = {32'b0, rd_words[req_ff.position[RW-1:0]]};

   assign pos_cmp = {{CW{1'b0}}, req_ff.position};
   assign cnt_cmp = {4'b0, count_ff};
   assign pos_bad = (pos_cmp >= cnt_cmp);
   assign full    = (count_ff >= CW'(DEPTH));

   assign len_ext = {5'b0, count_in};

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      cell_ctrl.op       = CELL_HOLD;
      cell_ctrl.position = req_ff.position;
      scan_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Latch the request on transfer.
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in.status         = STAT_OK;
            rsp_in.read_data      = '0;
            rsp_in.found_position = '0;
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
            case (req_ff.command)
               CMD_APPEND: begin
                  if (full) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     cell_ctrl.op = CELL_APPEND;
                     count_in     = count_ff + CW'(1);
                  end
               end
               CMD_INSERT: begin
                  if (pos_bad) begin
                     rsp_in.status = STAT_INDEX;
                  end else if (full) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     cell_ctrl.op = CELL_INSERT;
                     count_in     = count_ff + CW'(1);
                  end
               end
               CMD_DELETE: begin
                  if (pos_bad) begin
                     rsp_in.status = STAT_INDEX;
                  end else begin
                     cell_ctrl.op = CELL_DELETE;
                     count_in     = count_ff - CW'(1);
                  end
               end
               CMD_READ: begin
                  if (pos_bad) begin
                     rsp_in.status = STAT_INDEX;
                  end else begin
                     rsp_in.read_data = rd_ext[31:0];
                  end
               end
               CMD_FIND: begin
                  // Compare in every cell now, then hand off to the scanner.
                  cell_ctrl.op = CELL_COMPARE;
                  scan_start   = 1'b1;
                  rsp_valid_in = 1'b0;
                  state_in     = S_SCAN;
               end
               CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
            rsp_in.length   = len_ext[4:0];
            rsp_in.is_empty = (count_in == '0);
         end
         S_SCAN: begin
            // Hold until the scanner reports the first match or runs out.
            if (scan_res.done) begin
               rsp_in.status         = scan_res.found ? STAT_OK : STAT_NOTFOUND;
               rsp_in.read_data      = '0;
               rsp_in.found_position = scan_res.found ? scan_res.position : 4'd0;
               rsp_in.length         = len_ext[4:0];
               rsp_in.is_empty       = (count_ff == '0);
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Row of cells; each takes its neighbors' words for shifts.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word, right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = words[i+1];
      end
      ils_cell #(
         .DEPTH     (DEPTH),
         .WORD_BITS (WORD_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .word_value (value),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (words[i]),
         .match_out  (match[i])
      );
   end

   ils_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .match  (match),
      .result (scan_res)
   );

   `ILS_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= CW'(DEPTH))
   `ILS_ASSERT_NEXT(a_accept_exec, accept, state_ff == S_EXEC)
   `ILS_ASSERT_NEXT(a_exec_rsp, state_ff == S_EXEC && req_ff.command != CMD_FIND, rsp_valid_ff)
   `ILS_ASSERT_IMPL(a_scan_in_state, scan_res.done, state_ff == S_SCAN)

endmodule

`default_nettype wire

### verif/indexed_list_store_tb.sv
// Self-checking testbench for the ordered list store: directed edge cases and random traffic.
`timescale 1ns / 1ps

module indexed_list_store_tb;
   import ils_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int STALL_LIMIT = 200;
   localparam int DRAIN_WAIT  = 8;
   localparam int RANDOM_CMDS = 970;
   localparam int QUIET_TAIL  = 150;

   // Codes the block treats as no-ops; the package names only the real ones.
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   ils_req_type req_item = '0;
   logic        busy;
   logic        rsp_strobe;
   ils_rsp_type rsp_item;

   // Shadow copy of the list, advanced on every accepted command.
   logic [31:0] list_words [LIST_DEPTH];
   int unsigned list_len = 0;

   ils_rsp_type expected_rsp [$];
   int          error_count = 0;
   int          stall_cycles;
   int          cmd_transfers [8];
   int          status_seen [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_list_store #(
      .DEPTH     (LIST_DEPTH),
      .WORD_BITS (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Apply one command to the shadow list and return the response it must produce.
   function automatic ils_rsp_type list_apply(input ils_req_type cmd);
      ils_rsp_type r;
      int unsigned i;
      r = '0;
      r.status = STAT_OK;
      case (cmd.command)
         CMD_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               list_words[list_len] = cmd.item_value;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // Index check wins over the full check.
            if (cmd.position >= list_len) begin
               r.status = STAT_INDEX;
            end else if (list_len >= LIST_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (i = list_len; i > cmd.position; i--)
                  list_words[i] = list_words[i - 1];
               list_words[cmd.position] = cmd.item_value;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (cmd.position >= list_len) begin
               r.status = STAT_INDEX;
            end else begin
               for (i = cmd.position; i + 1 < list_len; i++)
                  list_words[i] = list_words[i + 1];
               list_len--;
            end
         end
         CMD_READ: begin
            if (cmd.position >= list_len)
               r.status = STAT_INDEX;
            else
               r.read_data = list_words[cmd.position];
         end
         CMD_FIND: begin
            // Scan from the top down so the last hit kept is the lowest position.
            r.status = STAT_NOTFOUND;
            for (i = list_len; i > 0; i--) begin
               if (list_words[i - 1] == cmd.item_value) begin
                  r.status = STAT_OK;
                  r.found_position = 4'(i - 1);
               end
            end
         end
         CMD_CLEAR: list_len = 0;
         default: ;
      endcase
      r.length = 5'(list_len);
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   function automatic ils_req_type make_cmd(input logic [2:0] code, input logic [3:0] pos,
                                            input logic [31:0] value);
      ils_req_type r;
      r.command = code;
      r.position = pos;
      r.item_value = value;
      return r;
   endfunction

   // Hold start until the transfer happens and busy drops again, then record what the response must be.
   // Leave start high on return so a following command goes out back to back.
   task automatic send_command(input ils_req_type cmd);
      ils_rsp_type outcome;
      req_item <= cmd;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      outcome = list_apply(cmd);
      expected_rsp.push_back(outcome);
      cmd_transfers[cmd.command]++;
      status_seen[outcome.status]++;
   endtask

   // Drop start and put junk on the request bus for the idle gap the caller asks for.
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      req_item <= make_cmd(3'($urandom), 4'($urandom), $urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Empty list: every positional command misses, find misses, spare code is a no-op.
   task automatic test_empty_list();
      send_command(make_cmd(CMD_READ, 4'd15, 32'h0));
      send_command(make_cmd(CMD_DELETE, 4'd0, 32'h0));
      send_command(make_cmd(CMD_INSERT, 4'd0, 32'hDEAD_BEEF));
      send_command(make_cmd(CMD_FIND, 4'd0, 32'h0));
      send_command(make_cmd(CMD_SPARE_B, 4'd15, 32'hFFFF_FFFF));
   endtask

   // Fill to capacity with extreme words and a duplicate, hit the full checks, read the top, find the duplicate.
   task automatic test_fill_to_capacity();
      logic [31:0] word;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         case (i)
            0:       word = 32'h0000_0000;
            1, 9:    word = 32'hFFFF_FFFF;
            2:       word = 32'h8000_0000;
            3:       word = 32'h0000_0001;
            4:       word = 32'hAAAA_AAAA;
            5:       word = 32'h5555_5555;
            default: word = 32'hC0DE_0000 + i;
         endcase
         send_command(make_cmd(CMD_APPEND, 4'(i), word));
      end
      send_command(make_cmd(CMD_APPEND, 4'd0, 32'h1234_5678));
      send_command(make_cmd(CMD_INSERT, 4'd15, 32'h1234_5678));
      send_command(make_cmd(CMD_READ, 4'd15, 32'h0));
      send_command(make_cmd(CMD_FIND, 4'd0, 32'hFFFF_FFFF));
   endtask

   // Delete at both ends, insert at and just below the length, send a spare code and a missing find, then clear.
   task automatic test_edge_positions();
      send_command(make_cmd(CMD_DELETE, 4'd15, 32'h0));
      send_command(make_cmd(CMD_DELETE, 4'd0, 32'h0));
      send_command(make_cmd(CMD_INSERT, 4'd14, 32'h0F0F_0F0F));
      send_command(make_cmd(CMD_INSERT, 4'd13, 32'hF0F0_F0F0));
      send_command(make_cmd(CMD_SPARE_A, 4'd7, 32'h0));
      send_command(make_cmd(CMD_FIND, 4'd3, 32'h1234_5678));
      send_command(make_cmd(CMD_CLEAR, 4'd9, 32'h0));
   endtask

   // Random traffic that swings the list between empty and full so the shift
   // paths and both error checks see every fill level.
   task automatic test_random_traffic(input int count);
      ils_req_type cmd;
      int          pick;
      int          done;
      bit          growing;
      done = 0;
      growing = 1'b1;
      while (done < count) begin
         if (list_len == 0)
            growing = 1'b1;
         else if (list_len == LIST_DEPTH && $urandom_range(0, 2) == 0)
            growing = 1'b0;

         pick = $urandom_range(0, 99);
         if (pick < 2)
            cmd.command = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
         else if (pick < 4)
            cmd.command = CMD_CLEAR;
         else if (pick < 20)
            cmd.command = CMD_READ;
         else if (pick < 38)
            cmd.command = CMD_FIND;
         else if (pick < 62)
            cmd.command = growing ? CMD_APPEND : CMD_DELETE;
         else if (pick < 80)
            cmd.command = growing ? CMD_INSERT : CMD_DELETE;
         else
            case ($urandom_range(0, 2))
               0:       cmd.command = CMD_APPEND;
               1:       cmd.command = CMD_INSERT;
               default: cmd.command = CMD_DELETE;
            endcase

         // Mostly valid positions, some at exactly the length, the rest anywhere.
         pick = $urandom_range(0, 9);
         if (list_len > 0 && pick < 7)
            cmd.position = 4'($urandom_range(0, list_len - 1));
         else if (pick == 7 && list_len < LIST_DEPTH)
            cmd.position = 4'(list_len);
         else
            cmd.position = 4'($urandom);

         pick = $urandom_range(0, 9);
         if (cmd.command == CMD_FIND && list_len > 0 && pick < 6)
            cmd.item_value = list_words[$urandom_range(0, list_len - 1)];
         else if (pick == 8)
            cmd.item_value = 32'h0;
         else if (pick == 9)
            cmd.item_value = 32'hFFFF_FFFF;
         else
            cmd.item_value = $urandom;

         send_command(cmd);
         if (cmd.command != CMD_SPARE_A && cmd.command != CMD_SPARE_B)
            done++;

         // Idle bursts through most of the run; a clean back-to-back tail.
         if (done < count - QUIET_TAIL && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 10));
      end
   endtask

   // Compare every strobed response with the oldest pending expectation.
   always @(posedge clock) begin
      ils_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("response with nothing pending: %p", rsp_item);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, rsp_item.read_data);
               error_count++;
            end
            if (rsp_item.found_position !== want.found_position) begin
               $error("found_position: expected %0d, actual %0d",
                      want.found_position, rsp_item.found_position);
               error_count++;
            end
            if (rsp_item.length !== want.length) begin
               $error("length: expected %0d, actual %0d", want.length, rsp_item.length);
               error_count++;
            end
            if (rsp_item.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_item.is_empty);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $error("no transfer on either channel for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      foreach (cmd_transfers[i]) cmd_transfers[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_capacity();
      test_edge_positions();
      test_random_traffic(RANDOM_CMDS);

      // Stop sending, drain what is pending, then let the bench run quiet before the summary.
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Commands sent: %0d append, %0d insert, %0d delete, %0d read, %0d find, %0d clear, %0d spare",
               cmd_transfers[CMD_APPEND], cmd_transfers[CMD_INSERT], cmd_transfers[CMD_DELETE],
               cmd_transfers[CMD_READ], cmd_transfers[CMD_FIND], cmd_transfers[CMD_CLEAR],
               cmd_transfers[CMD_SPARE_A] + cmd_transfers[CMD_SPARE_B]);
      $display("Outcomes: %0d ok, %0d index error, %0d list full, %0d not found",
               status_seen[STAT_OK], status_seen[STAT_INDEX], status_seen[STAT_FULL],
               status_seen[STAT_NOTFOUND]);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
